// ===== design/dubins_lsl_rsr_word_macros.svh =====
// ----------------------------------------------------------------------------
// Dubins LSL/RSR word: assertion macros
// Implication forms used by the checker file.
// ----------------------------------------------------------------------------
`ifndef DUBINS_LSL_RSR_WORD_MACROS_SVH
`define DUBINS_LSL_RSR_WORD_MACROS_SVH

// same-cycle implication
`define DLR_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dubins_lsl_rsr_word: same-cycle check failed");

// next-cycle implication
`define DLR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dubins_lsl_rsr_word: next-cycle check failed");

`endif

// ===== design/dlr_pkg.sv =====
// ----------------------------------------------------------------------------
// Dubins LSL/RSR word: package
// Angle constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package dlr_pkg;

	localparam int TWO_PI_Q12  = 25736;
	localparam int TWO_PI16    = 411775;
	localparam int PI16        = 205887;
	localparam int HALF_PI16   = 102944;
	localparam int CORDIC_K16  = 39797;
	localparam int STEPS       = 16;
	localparam int SQRT_STEPS  = 26;

	typedef logic signed [19:0] trig_t;
	typedef logic signed [25:0] vec_x_t;
	typedef logic signed [20:0] theta_t;

	// atan(2^-i) in Q16 radians
	function automatic logic [15:0] atan_q16(input int unsigned i);
		logic [15:0] v;
		case (i)
			0:       v = 16'd51472;
			1:       v = 16'd30386;
			2:       v = 16'd16055;
			3:       v = 16'd8150;
			4:       v = 16'd4091;
			5:       v = 16'd2047;
			6:       v = 16'd1024;
			7:       v = 16'd512;
			8:       v = 16'd256;
			9:       v = 16'd128;
			10:      v = 16'd64;
			11:      v = 16'd32;
			12:      v = 16'd16;
			13:      v = 16'd8;
			14:      v = 16'd4;
			15:      v = 16'd2;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== design/dlr_sincos.sv =====
// ----------------------------------------------------------------------------
// Dubins LSL/RSR word: sine/cosine pipeline
// Fold into [-pi/2, pi/2], then 16 CORDIC rotation stages.
// ----------------------------------------------------------------------------
module dlr_sincos (
	input  logic                 clk,
	input  logic                 en,
	input  logic [18:0]          angle,
	output dlr_pkg::trig_t       cos_v,
	output dlr_pkg::trig_t       sin_v
);
	import dlr_pkg::*;

	localparam trig_t PI_R      = 20'(PI16);
	localparam trig_t HALF_PI_R = 20'(HALF_PI16);
	localparam trig_t TWO_PI_R  = 20'(TWO_PI16);
	localparam trig_t K_R       = 20'(CORDIC_K16);

	trig_t x_s [0:STEPS];
	trig_t y_s [0:STEPS];
	trig_t z_s [0:STEPS];
	logic  flip_s [0:STEPS];

	trig_t z_wrap;
	trig_t z_fold;
	logic  flip_in;

	always_comb begin
		z_wrap = signed'({1'b0, angle});
		if (z_wrap > PI_R) begin
			z_wrap = z_wrap - TWO_PI_R;
		end
		z_fold  = z_wrap;
		flip_in = 1'b0;
		if (z_wrap > HALF_PI_R) begin
			z_fold  = z_wrap - PI_R;
			flip_in = 1'b1;
		end else if (z_wrap < -HALF_PI_R) begin
			z_fold  = z_wrap + PI_R;
			flip_in = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= K_R;
			y_s[0]    <= '0;
			z_s[0]    <= z_fold;
			flip_s[0] <= flip_in;
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam trig_t ATAN_K = signed'({4'b0, atan_q16(k)});
		always_ff @(posedge clk) begin
			if (en) begin
				if (z_s[k] >= 0) begin
					x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] - ATAN_K;
				end else begin
					x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] + ATAN_K;
				end
				flip_s[k+1] <= flip_s[k];
			end
		end
	end

	assign cos_v = flip_s[STEPS] ? -x_s[STEPS] : x_s[STEPS];
	assign sin_v = flip_s[STEPS] ? -y_s[STEPS] : y_s[STEPS];

endmodule

// ===== design/dlr_atan2.sv =====
// ----------------------------------------------------------------------------
// Dubins LSL/RSR word: atan2 pipeline
// Half-plane fold, then 16 CORDIC vectoring stages.
// ----------------------------------------------------------------------------
module dlr_atan2 (
	input  logic                 clk,
	input  logic                 en,
	input  dlr_pkg::vec_x_t      x_in,
	input  dlr_pkg::trig_t       y_in,
	output dlr_pkg::theta_t      theta
);
	import dlr_pkg::*;

	typedef logic signed [27:0] wide_t;

	localparam theta_t PI_R = 21'(PI16);

	wide_t  x_s [0:STEPS];
	wide_t  y_s [0:STEPS];
	theta_t z_s [0:STEPS];
	logic   zero_s [0:STEPS];

	wide_t x_ext;
	wide_t y_ext;

	assign x_ext = 28'(x_in);
	assign y_ext = 28'(y_in);

	// left half-plane: negate the vector and start from pi
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			if (x_in < 0) begin
				x_s[0] <= -x_ext;
				y_s[0] <= -y_ext;
				z_s[0] <= PI_R;
			end else begin
				x_s[0] <= x_ext;
				y_s[0] <= y_ext;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam theta_t ATAN_K = signed'({5'b0, atan_q16(k)});
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[k] > 0) begin
					x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] + ATAN_K;
				end else begin
					x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] - ATAN_K;
				end
				zero_s[k+1] <= zero_s[k];
			end
		end
	end

	assign theta = zero_s[STEPS] ? '0 : z_s[STEPS];

endmodule

// ===== design/dlr_isqrt.sv =====
// ----------------------------------------------------------------------------
// Dubins LSL/RSR word: magnitude pipeline
// Square, sum, then one root bit per stage.
// ----------------------------------------------------------------------------
module dlr_isqrt (
	input  logic                 clk,
	input  logic                 en,
	input  dlr_pkg::vec_x_t      x_in,
	input  dlr_pkg::trig_t       y_in,
	output logic [25:0]          root
);
	import dlr_pkg::*;

	logic signed [51:0] xx_s;
	logic signed [39:0] yy_s;
	logic [51:0]        v_s [0:SQRT_STEPS];
	logic [51:0]        r_s [0:SQRT_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s   <= x_in * x_in;
			yy_s   <= y_in * y_in;
			v_s[0] <= unsigned'(xx_s) + 52'(unsigned'(yy_s));
			r_s[0] <= '0;
		end
	end

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_bit
		localparam logic [51:0] BIT_J = 52'(1) << (2 * (SQRT_STEPS - 1 - j));
		logic [51:0] trial;
		assign trial = r_s[j] + BIT_J;
		always_ff @(posedge clk) begin
			if (en) begin
				if (v_s[j] >= trial) begin
					v_s[j+1] <= v_s[j] - trial;
					r_s[j+1] <= (r_s[j] >> 1) + BIT_J;
				end else begin
					v_s[j+1] <= v_s[j];
					r_s[j+1] <= r_s[j] >> 1;
				end
			end
		end
	end

	assign root = r_s[SQRT_STEPS][25:0];

endmodule

// ===== design/dubins_lsl_rsr_word.sv =====
// ----------------------------------------------------------------------------
// Dubins LSL/RSR word evaluator
// Gives arc t, straight p and arc q of the LSL or RSR Dubins word.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while no result is stalled; every stage is a fixed pipeline register.
// The 16-stage sine/cosine CORDIC and the 28-stage root pipeline set depth.
// Stall: a stalled result freezes the whole pipeline and stalls commands.
// Reset: arst_n clears the valid bits at once; data registers are not reset.
// ----------------------------------------------------------------------------
module dubins_lsl_rsr_word (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic        func,
	input  logic [14:0] start_heading,
	input  logic [14:0] goal_heading,
	input  logic [15:0] distance,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [14:0] first_turn,
	output logic [15:0] straight_len,
	output logic [14:0] last_turn,
	output logic        len_saturated
);
	import dlr_pkg::*;

	// stage counts
	localparam int L_SC  = STEPS + 1;          // sine/cosine
	localparam int L_AT  = STEPS + 1;          // atan2
	localparam int L_SQ  = SQRT_STEPS + 2;     // magnitude
	localparam int L_PAD = L_SQ - L_AT;        // align theta with the root
	localparam int LAT   = L_SC + 1 + L_SQ + 1;

	localparam logic [14:0]        TWO_PI_H = 15'(TWO_PI_Q12);
	localparam logic signed [21:0] TWO_PI_W = 22'(TWO_PI16);

	logic en;

	// Whole pipeline advances together; hold everything while a result waits.
	assign en        = !(res_valid && res_stall);
	assign cmd_stall = !en;

	// ------------------------------------------------------------------
	// valid bits travel with the data
	// ------------------------------------------------------------------
	logic vld_s [0:LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= cmd_valid;
			for (int i = 1; i < LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	assign res_valid = vld_s[LAT-1];

	// ------------------------------------------------------------------
	// heading reduction mod 2pi (a 15-bit code wraps at most once)
	// ------------------------------------------------------------------
	logic [14:0] ha;
	logic [14:0] hb;

	assign ha = (start_heading >= TWO_PI_H) ? start_heading - TWO_PI_H : start_heading;
	assign hb = (goal_heading  >= TWO_PI_H) ? goal_heading  - TWO_PI_H : goal_heading;

	// ------------------------------------------------------------------
	// sine/cosine of both headings
	// ------------------------------------------------------------------
	trig_t cos_a;
	trig_t sin_a;
	trig_t cos_b;
	trig_t sin_b;

	dlr_sincos u_sc_a (
		.clk   (clk),
		.en    (en),
		.angle ({ha, 4'b0}),
		.cos_v (cos_a),
		.sin_v (sin_a)
	);

	dlr_sincos u_sc_b (
		.clk   (clk),
		.en    (en),
		.angle ({hb, 4'b0}),
		.cos_v (cos_b),
		.sin_v (sin_b)
	);

	// side data riding alongside the trig pipelines
	logic        e_func_s [0:L_SC-1];
	logic [18:0] e_a_s    [0:L_SC-1];
	logic [18:0] e_b_s    [0:L_SC-1];
	logic [23:0] e_d_s    [0:L_SC-1];

	always_ff @(posedge clk) begin
		if (en) begin
			e_func_s[0] <= func;
			e_a_s[0]    <= {ha, 4'b0};
			e_b_s[0]    <= {hb, 4'b0};
			e_d_s[0]    <= {distance, 8'b0};
			for (int i = 1; i < L_SC; i++) begin
				e_func_s[i] <= e_func_s[i-1];
				e_a_s[i]    <= e_a_s[i-1];
				e_b_s[i]    <= e_b_s[i-1];
				e_d_s[i]    <= e_d_s[i-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// combine: the center-to-center vector (X, Y)
	// ------------------------------------------------------------------
	vec_x_t      c_x_s;
	trig_t       c_y_s;
	logic        c_func_s;
	logic [18:0] c_a_s;
	logic [18:0] c_b_s;

	vec_x_t d_w;

	assign d_w = signed'({2'b0, e_d_s[L_SC-1]});

	always_ff @(posedge clk) begin
		if (en) begin
			c_func_s <= e_func_s[L_SC-1];
			c_a_s    <= e_a_s[L_SC-1];
			c_b_s    <= e_b_s[L_SC-1];
			if (e_func_s[L_SC-1]) begin
				// right-straight-right
				c_x_s <= d_w - 26'(sin_a) + 26'(sin_b);
				c_y_s <= cos_a - cos_b;
			end else begin
				// left-straight-left
				c_x_s <= d_w + 26'(sin_a) - 26'(sin_b);
				c_y_s <= cos_b - cos_a;
			end
		end
	end

	// ------------------------------------------------------------------
	// heading of the vector and its length, in parallel
	// ------------------------------------------------------------------
	theta_t      theta;
	logic [25:0] root;

	dlr_atan2 u_atan2 (
		.clk   (clk),
		.en    (en),
		.x_in  (c_x_s),
		.y_in  (c_y_s),
		.theta (theta)
	);

	dlr_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.x_in (c_x_s),
		.y_in (c_y_s),
		.root (root)
	);

	theta_t      th_s     [0:L_PAD-1];
	logic        p_func_s [0:L_SQ-1];
	logic [18:0] p_a_s    [0:L_SQ-1];
	logic [18:0] p_b_s    [0:L_SQ-1];

	always_ff @(posedge clk) begin
		if (en) begin
			th_s[0] <= theta;
			for (int i = 1; i < L_PAD; i++) begin
				th_s[i] <= th_s[i-1];
			end
			p_func_s[0] <= c_func_s;
			p_a_s[0]    <= c_a_s;
			p_b_s[0]    <= c_b_s;
			for (int i = 1; i < L_SQ; i++) begin
				p_func_s[i] <= p_func_s[i-1];
				p_a_s[i]    <= p_a_s[i-1];
				p_b_s[i]    <= p_b_s[i-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// arcs, rounding, saturation
	// ------------------------------------------------------------------
	function automatic logic [14:0] arc_q12(input logic signed [21:0] v);
		logic signed [21:0] r;
		logic [17:0]        q;
		r = v;
		if (r < 0) begin
			r = r + TWO_PI_W;
		end
		if (r < 0) begin
			r = r + TWO_PI_W;
		end
		if (r >= TWO_PI_W) begin
			r = r - TWO_PI_W;
		end
		q = 18'((r + 22'sd8) >>> 4);
		return (q >= 18'(TWO_PI_Q12)) ? 15'd0 : q[14:0];
	endfunction

	logic signed [21:0] th_w;
	logic signed [21:0] a_w;
	logic signed [21:0] b_w;
	logic signed [21:0] t_w;
	logic signed [21:0] q_w;
	logic [18:0]        p_round;

	assign th_w    = 22'(th_s[L_PAD-1]);
	assign a_w     = signed'({3'b0, p_a_s[L_SQ-1]});
	assign b_w     = signed'({3'b0, p_b_s[L_SQ-1]});
	assign t_w     = p_func_s[L_SQ-1] ? a_w - th_w : th_w - a_w;
	assign q_w     = p_func_s[L_SQ-1] ? th_w - b_w : b_w - th_w;
	assign p_round = 19'((27'(root) + 27'd128) >> 8);

	always_ff @(posedge clk) begin
		if (en) begin
			first_turn <= arc_q12(t_w);
			last_turn  <= arc_q12(q_w);
			if (p_round > 19'hFFFF) begin
				straight_len  <= 16'hFFFF;
				len_saturated <= 1'b1;
			end else begin
				straight_len  <= p_round[15:0];
				len_saturated <= 1'b0;
			end
		end
	end

endmodule

// ===== design/dlr_checker.sv =====
// ----------------------------------------------------------------------------
// Dubins LSL/RSR word: port checker
// Watches the top-level ports; bound to every instance of the top level.
// ----------------------------------------------------------------------------
`include "dubins_lsl_rsr_word_macros.svh"

module dlr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_stall,
	input logic        res_valid,
	input logic        res_stall,
	input logic [14:0] first_turn,
	input logic [15:0] straight_len,
	input logic [14:0] last_turn,
	input logic        len_saturated
);
	import dlr_pkg::*;

	// hold a stalled result
	`DLR_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(first_turn) && $stable(straight_len) && $stable(last_turn))
	// commands stall only behind a stalled result
	`DLR_ASSERT_IMPL(a_cmd_stall, cmd_stall, res_valid && res_stall)
	// arcs stay below 2pi
	`DLR_ASSERT_IMPL(a_arc_range, res_valid, (first_turn < 15'(TWO_PI_Q12)) && (last_turn < 15'(TWO_PI_Q12)))
	// clamped length reads full scale
	`DLR_ASSERT_IMPL(a_sat_full, res_valid && len_saturated, straight_len == 16'hFFFF)

endmodule

bind dubins_lsl_rsr_word dlr_checker u_dlr_checker (.*);
